// ===== src/dvr_pkg.sv =====
// dvr_pkg: shared constants, types and helpers of the distance-vector route core
// no dependencies; imported by every module of the core
package dvr_pkg;

    localparam int NODES    = 4;              // nodes in the network
    localparam int MAXN     = 4;              // cost fields carried per item and per packet
    localparam int INF_COST = 999;            // cost that stands for no route
    localparam int COST_W   = 10;             // width of one cost field
    localparam int NODE_W   = 2;              // width of a node identifier field
    localparam int IDX_W    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W    = $clog2(NODES) + 1;

    localparam int S_DATA_W = 56;             // slave tdata, packed fields padded to bytes
    localparam int M_DATA_W = 48;             // master tdata, packed fields padded to bytes
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [COST_W-1:0] INF = COST_W'(INF_COST);

    // item kinds
    localparam logic [KIND_W-1:0] KIND_INIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LINK   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COST0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COST1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COST2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COST3 = 3'd4;

    // lane operations
    localparam logic [1:0] LANE_HOLD   = 2'd0;
    localparam logic [1:0] LANE_INIT   = 2'd1;
    localparam logic [1:0] LANE_UPDATE = 2'd2;
    localparam logic [1:0] LANE_DIAG   = 2'd3;

    typedef logic [COST_W-1:0] cost_t;
    typedef cost_t [NODES-1:0] cost_vec_t;

    // control from the sequencer to every lane
    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] sender;
        cost_t            sender_cost;
    } lane_ctrl_t;

    // clamp a grown cost back to infinity
    function automatic cost_t sat_cost(input logic [COST_W:0] v);
        sat_cost = (v > (COST_W+1)'(INF_COST)) ? INF : v[COST_W-1:0];
    endfunction

endpackage

// ===== src/dvr_lane.sv =====
// dvr_lane: one destination row of the cost table, its update and its minimum
// depends on dvr_pkg
module dvr_lane
(
    input  logic               clk,
    input  logic               rst_n,
    input  dvr_pkg::lane_ctrl_t ctrl,
    input  logic [dvr_pkg::IDX_W-1:0] row_idx,
    input  dvr_pkg::cost_t     diag_cost,
    input  dvr_pkg::cost_t     sender_dist,
    output logic               lowered,
    output dvr_pkg::cost_t     row_min
);
    import dvr_pkg::*;

    cost_vec_t row_reg;
    cost_vec_t row_next;
    cost_t     cand;
    cost_t     min_acc;

    // candidate cost through the sender
    always_comb
    begin
        if (sender_dist >= INF)
            cand = INF;
        else
            cand = sat_cost({1'b0, ctrl.sender_cost} + {1'b0, sender_dist});
    end

    // row rewrite for the current operation
    always_comb
    begin
        row_next = row_reg;
        lowered  = 1'b0;
        case (ctrl.op)
            LANE_INIT:
            begin
                for (int h = 0; h < NODES; h++)
                begin
                    row_next[h] = (IDX_W'(h) == row_idx) ? diag_cost : INF;
                end
            end
            LANE_DIAG:
            begin
                row_next[row_idx] = diag_cost;
            end
            LANE_UPDATE:
            begin
                if (cand < row_reg[ctrl.sender])
                begin
                    row_next[ctrl.sender] = cand;
                    lowered               = 1'b1;
                end
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    // row storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int h = 0; h < NODES; h++)
            begin
                row_reg[h] <= INF;
            end
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    // minimum over the next hops
    always_comb
    begin
        min_acc = INF;
        for (int h = 0; h < NODES; h++)
        begin
            if (row_reg[h] < min_acc)
                min_acc = row_reg[h];
        end
        row_min = min_acc;
    end

endmodule

// ===== src/dvr_merge.sv =====
// dvr_merge: combines the lane minimums into the new best-cost vector
// depends on dvr_pkg
module dvr_merge
(
    input  dvr_pkg::cost_vec_t          row_mins,
    input  dvr_pkg::cost_vec_t          prev_best,
    input  logic                        force_self,
    input  logic [dvr_pkg::NODE_W-1:0]  own_node,
    output dvr_pkg::cost_vec_t          best_next,
    output logic                        changed
);
    import dvr_pkg::*;

    // self entry forced to zero after init and link change
    always_comb
    begin
        for (int d = 0; d < NODES; d++)
        begin
            if (force_self && ({1'b0, own_node} == (NODE_W+1)'(d)))
                best_next[d] = '0;
            else
                best_next[d] = row_mins[d];
        end
        changed = (best_next != prev_best);
    end

endmodule

// ===== src/distance_vector_route_update_core.sv =====
// distance_vector_route_update_core: one node's distance-vector routing engine
// first packet registered after the apply, merge and send states, then one packet per
//   cycle while m_tready is high; an item dropped at apply goes back to idle, one that
//   sends nothing goes back from merge; a new item is taken only in idle, after the
//   apply / merge / send sequence around the per-row lanes
// reset: rst_n clears table, best and link costs to infinity, registers to 0,0,1,3,7
// depends on dvr_pkg, dvr_lane, dvr_merge
module distance_vector_route_update_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sender[1:0], dist_to_node0[11:2], dist_to_node1[21:12], dist_to_node2[31:22],
    // dist_to_node3[41:32], changed_link[43:42], new_link_cost[53:44], zero pad
    input  logic [dvr_pkg::S_DATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  logic [dvr_pkg::KIND_W-1:0]     s_tuser,
    // vector packets
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // to_node[1:0], from_node[3:2], best_to_node0[13:4], best_to_node1[23:14],
    // best_to_node2[33:24], best_to_node3[43:34], zero pad
    output logic [dvr_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dvr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dvr_pkg::COST_W-1:0]     cfg_data
);
    import dvr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_APPLY = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;
    localparam logic [1:0] ST_SEND  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [NODE_W-1:0] own_node_reg;
    cost_vec_t         init_cost_reg;
    cost_vec_t         link_costs_reg, link_next;
    cost_vec_t         best_reg;

    // latched item
    logic [KIND_W-1:0] kind_reg;
    logic [NODE_W-1:0] sender_reg;
    cost_t             dist_reg [MAXN];
    logic [NODE_W-1:0] link_sel_reg;
    cost_t             new_cost_reg;

    logic              force_reg, force_next;
    logic              emit_all_reg, emit_all_next;
    logic [NODES-1:0]  mask_reg, mask_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [NODE_W-1:0] out_to_reg, out_from_reg;
    cost_vec_t         out_best_reg;
    logic              out_last_reg;
    logic              load_pkt;

    lane_ctrl_t        lane_ctrl;
    logic [NODES-1:0]  lane_lowered;
    cost_vec_t         row_mins;
    cost_vec_t         best_next;
    logic              best_changed;

    logic              sender_ok;
    logic              link_ok;
    logic [NODES-1:0]  nbr_mask;
    logic [IDX_W-1:0]  pick;
    logic [NODES-1:0]  mask_left;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_reg  <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                init_cost_reg[i] <= (i == 0) ? cost_t'(0) : (i == 1) ? cost_t'(1) :
                                    (i == 2) ? cost_t'(3) : cost_t'(7);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OWN_NODE:   own_node_reg <= cfg_data[NODE_W-1:0];
                CFG_INIT_COST0: init_cost_reg[0] <= cfg_data;
                CFG_INIT_COST1: init_cost_reg[1 % NODES] <=
                                (NODES > 1) ? cfg_data : init_cost_reg[1 % NODES];
                CFG_INIT_COST2: init_cost_reg[2 % NODES] <=
                                (NODES > 2) ? cfg_data : init_cost_reg[2 % NODES];
                CFG_INIT_COST3: init_cost_reg[3 % NODES] <=
                                (NODES > 3) ? cfg_data : init_cost_reg[3 % NODES];
                default:        own_node_reg <= own_node_reg;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg     <= s_tuser;
            sender_reg   <= s_tdata[1:0];
            for (int j = 0; j < MAXN; j++)
            begin
                dist_reg[j] <= s_tdata[NODE_W + j*COST_W +: COST_W];
            end
            link_sel_reg <= s_tdata[NODE_W + MAXN*COST_W +: NODE_W];
            new_cost_reg <= s_tdata[2*NODE_W + MAXN*COST_W +: COST_W];
        end
    end

    // validity of the latched item
    assign sender_ok = ({1'b0, sender_reg} < (NODE_W+1)'(NODES)) &&
                       (link_costs_reg[sender_reg[IDX_W-1:0]] < INF);
    assign link_ok   = ({1'b0, link_sel_reg} < (NODE_W+1)'(NODES));

    // lane control and link cost rewrite during apply
    always_comb
    begin
        link_next             = link_costs_reg;
        lane_ctrl.op          = LANE_HOLD;
        lane_ctrl.sender      = sender_reg[IDX_W-1:0];
        lane_ctrl.sender_cost = link_costs_reg[sender_reg[IDX_W-1:0]];
        if (state_reg == ST_APPLY)
        begin
            case (kind_reg)
                KIND_INIT:
                begin
                    for (int d = 0; d < NODES; d++)
                    begin
                        link_next[d] = sat_cost({1'b0, init_cost_reg[d]});
                    end
                    lane_ctrl.op = LANE_INIT;
                end
                KIND_UPDATE:
                begin
                    if (sender_ok)
                        lane_ctrl.op = LANE_UPDATE;
                end
                KIND_LINK:
                begin
                    if (link_ok)
                    begin
                        link_next[link_sel_reg[IDX_W-1:0]] = sat_cost({1'b0, new_cost_reg});
                        lane_ctrl.op = LANE_DIAG;
                    end
                end
                default:
                begin
                    lane_ctrl.op = LANE_HOLD;
                end
            endcase
        end
    end

    // one lane per destination row
    for (genvar d = 0; d < NODES; d++)
    begin : g_lane
        dvr_lane u_lane
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (lane_ctrl),
            .row_idx     (IDX_W'(d)),
            .diag_cost   (link_next[d]),
            .sender_dist (dist_reg[d]),
            .lowered     (lane_lowered[d]),
            .row_min     (row_mins[d])
        );
    end

    dvr_merge u_merge
    (
        .row_mins   (row_mins),
        .prev_best  (best_reg),
        .force_self (force_reg),
        .own_node   (own_node_reg),
        .best_next  (best_next),
        .changed    (best_changed)
    );

    // neighbours: other nodes with a finite link
    always_comb
    begin
        for (int k = 0; k < NODES; k++)
        begin
            nbr_mask[k] = ({1'b0, own_node_reg} != (NODE_W+1)'(k)) &&
                          (link_costs_reg[k] < INF);
        end
    end

    // lowest pending neighbour
    always_comb
    begin
        pick = '0;
        for (int k = NODES - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
                pick = IDX_W'(k);
        end
        mask_left       = mask_reg;
        mask_left[pick] = 1'b0;
    end

    assign load_pkt = (state_reg == ST_SEND) && (!out_valid_reg || m_tready);

    // last packet of the run: no neighbour left or the packet cap reached
    function automatic logic out_last_next();
        out_last_next = (mask_left == '0) || (cnt_reg == CNT_W'(NODES - 2));
    endfunction

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        force_next    = force_reg;
        emit_all_next = emit_all_reg;
        mask_next     = mask_reg;
        cnt_next      = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                force_next    = 1'b0;
                emit_all_next = 1'b0;
                state_next    = ST_IDLE;
                case (kind_reg)
                    KIND_INIT:
                    begin
                        force_next    = 1'b1;
                        emit_all_next = 1'b1;
                        state_next    = ST_MERGE;
                    end
                    KIND_UPDATE:
                    begin
                        if (sender_ok && (|lane_lowered))
                            state_next = ST_MERGE;
                    end
                    KIND_LINK:
                    begin
                        if (link_ok)
                        begin
                            force_next = 1'b1;
                            state_next = ST_MERGE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MERGE:
            begin
                mask_next  = nbr_mask;
                cnt_next   = '0;
                state_next = ((emit_all_reg || best_changed) && (|nbr_mask)) ?
                             ST_SEND : ST_IDLE;
            end
            ST_SEND:
            begin
                if (load_pkt)
                begin
                    mask_next = mask_left;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (out_last_next())
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and routing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            force_reg    <= 1'b0;
            emit_all_reg <= 1'b0;
            mask_reg     <= '0;
            cnt_reg      <= '0;
            for (int d = 0; d < NODES; d++)
            begin
                link_costs_reg[d] <= INF;
                best_reg[d]       <= INF;
            end
        end
        else
        begin
            state_reg      <= state_next;
            force_reg      <= force_next;
            emit_all_reg   <= emit_all_next;
            mask_reg       <= mask_next;
            cnt_reg        <= cnt_next;
            link_costs_reg <= link_next;
            if (state_reg == ST_MERGE)
                best_reg <= best_next;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_pkt)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_pkt)
        begin
            out_to_reg   <= NODE_W'(pick);
            out_from_reg <= own_node_reg;
            out_best_reg <= best_reg;
            out_last_reg <= out_last_next();
        end
    end

    // packet packing
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata[NODE_W-1:0]        = out_to_reg;
    assign m_tdata[2*NODE_W-1:NODE_W] = out_from_reg;
    for (genvar j = 0; j < MAXN; j++)
    begin : g_best
        if (j < NODES)
        begin : g_real
            assign m_tdata[2*NODE_W + j*COST_W +: COST_W] = out_best_reg[j];
        end
        else
        begin : g_none
            assign m_tdata[2*NODE_W + j*COST_W +: COST_W] = INF;
        end
    end
    assign m_tdata[M_DATA_W-1:2*NODE_W + MAXN*COST_W] = '0;

endmodule

// ===== src/dvr_checker.sv =====
// dvr_checker: port-level checks of the distance-vector route core, bound to the top level
// depends on dvr_pkg and distance_vector_route_update_core
module dvr_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dvr_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                           m_tlast
);
    import dvr_pkg::*;

    // a stalled packet holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled packet changed");

    // one item at a time: an input transfer closes the input side
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // a packet never goes to this node itself
    a_not_self: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != m_tdata[3:2])
        else $error("packet addressed to own node");

    // every cost sent is saturated
    a_cost_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[13:4] <= INF && m_tdata[23:14] <= INF &&
                     m_tdata[33:24] <= INF && m_tdata[43:34] <= INF)
        else $error("cost above infinity in packet");

endmodule

bind distance_vector_route_update_core dvr_checker u_dvr_checker (.*);

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for the distance-vector route update core
// drives route items and register writes, works out every vector packet and checks it
// depends on dvr_pkg and distance_vector_route_update_core
module tb_top;
    import dvr_pkg::*;

    localparam logic [KIND_W-1:0]    KIND_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 75;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int GAP_PCT        = 37;
    localparam int PREDICTED      = -1;
    localparam cost_vec_t ALL_INF = {NODES{INF}};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] sender;
        cost_vec_t         dists;
        logic [NODE_W-1:0] link;
        cost_t             link_cost;
    } route_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] to_node;
        logic [NODE_W-1:0] from_node;
        cost_vec_t         best;
        logic              last;
    } vec_pkt_t;

    // one row of the directed table; exp_n of PREDICTED leaves the packets to the predictor
    typedef struct {
        route_item_t             item;
        int                      exp_n;
        cost_vec_t               exp_best;
        logic [3*NODE_W-1:0]     exp_dests;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COST_W-1:0]      cfg_data = '0;

    // predictor state, reset values of the node
    logic [NODE_W-1:0]      own_id = '0;
    cost_t                  init_cost [NODES] = '{10'd0, 10'd1, 10'd3, 10'd7};
    cost_t                  route_tbl [NODES][NODES];
    cost_vec_t              best_vec = ALL_INF;
    cost_vec_t              link_vec = ALL_INF;

    vec_pkt_t               step_pkts [$];
    vec_pkt_t               expected_pkts [$];
    directed_row_t          directed_rows [$];
    int                     fail_count = 0;
    int                     stall_cycles = 0;
    bit                     send_gaps_on = 1'b1;
    bit                     recv_gaps_on = 1'b1;

    distance_vector_route_update_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic cost_t clamp_cost(input int unsigned v);
        return (v > INF_COST) ? INF : cost_t'(v);
    endfunction

    function automatic cost_vec_t cv(input int c0, input int c1, input int c2, input int c3);
        return {cost_t'(c3), cost_t'(c2), cost_t'(c1), cost_t'(c0)};
    endfunction

    // mostly small costs so that routes keep improving, some infinite or oversized
    function automatic cost_t rand_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return cost_t'($urandom_range(0, 15));
        else if (r < 85)
            return INF;
        else
            return cost_t'($urandom_range(0, 1023));
    endfunction

    function automatic directed_row_t drow(input logic [KIND_W-1:0] kind,
                                           input logic [NODE_W-1:0] sender,
                                           input cost_vec_t dists,
                                           input logic [NODE_W-1:0] link,
                                           input cost_t link_cost,
                                           input int exp_n,
                                           input cost_vec_t exp_best,
                                           input logic [3*NODE_W-1:0] exp_dests);
        directed_row_t row;
        row.item      = {kind, sender, dists, link, link_cost};
        row.exp_n     = exp_n;
        row.exp_best  = exp_best;
        row.exp_dests = exp_dests;
        return row;
    endfunction

    // minimum of every destination row over all next hops
    function automatic void row_minimums();
        cost_t m;
        for (int d = 0; d < NODES; d++)
        begin
            m = INF;
            for (int h = 0; h < NODES; h++)
                if (route_tbl[d][h] < m)
                    m = route_tbl[d][h];
            best_vec[d] = m;
        end
    endfunction

    // advance the node by one item and collect the vector packets it sends
    function automatic void route_step(input route_item_t it);
        cost_vec_t prev;
        cost_t     c;
        logic      lowered;
        logic      send;
        vec_pkt_t  tail;
        step_pkts.delete();
        prev    = best_vec;
        lowered = 1'b0;
        send    = 1'b0;
        case (it.kind)
            KIND_INIT:
            begin
                for (int d = 0; d < NODES; d++)
                    for (int h = 0; h < NODES; h++)
                        route_tbl[d][h] = INF;
                for (int d = 0; d < NODES; d++)
                begin
                    link_vec[d]     = clamp_cost(init_cost[d]);
                    route_tbl[d][d] = link_vec[d];
                    best_vec[d]     = link_vec[d];
                end
                best_vec[own_id] = '0;
                send = 1'b1;
            end
            KIND_UPDATE:
            begin
                // senders without a direct link are dropped
                if (link_vec[it.sender] < INF)
                begin
                    for (int d = 0; d < NODES; d++)
                    begin
                        c = (it.dists[d] >= INF) ? INF :
                            clamp_cost(int'(link_vec[it.sender]) + int'(it.dists[d]));
                        if (c < route_tbl[d][it.sender])
                        begin
                            route_tbl[d][it.sender] = c;
                            lowered = 1'b1;
                        end
                    end
                    if (lowered)
                    begin
                        row_minimums();
                        send = (best_vec != prev);
                    end
                end
            end
            KIND_LINK:
            begin
                link_vec[it.link] = clamp_cost(it.link_cost);
                for (int d = 0; d < NODES; d++)
                    route_tbl[d][d] = link_vec[d];
                row_minimums();
                best_vec[own_id] = '0;
                send = (best_vec != prev);
            end
            default:
            begin
            end
        endcase
        // one packet per neighbour in node order, last one flagged
        if (send)
            for (int k = 0; k < NODES; k++)
                if (k != own_id && link_vec[k] < INF)
                    step_pkts.push_back({NODE_W'(k), own_id, best_vec, 1'b0});
        if (step_pkts.size() != 0)
        begin
            tail = step_pkts.pop_back();
            tail.last = 1'b1;
            step_pkts.push_back(tail);
        end
    endfunction

    // register write transfer; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cost_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_OWN_NODE)
            own_id = val[NODE_W-1:0];
        else if (idx inside {[CFG_INIT_COST0:CFG_INIT_COST3]})
            init_cost[IDX_W'(idx - CFG_INIT_COST0)] = val;
    endtask

    // send one item, then queue the packets it should cause
    task automatic apply_item(input route_item_t it, input int exp_n,
                              input cost_vec_t exp_best, input logic [3*NODE_W-1:0] exp_dests);
        while (send_gaps_on && $urandom_range(0, 99) < GAP_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {2'b00, it.link_cost, it.link, it.dists, it.sender};
        do @(posedge clk); while (!s_tready);
        route_step(it);
        if (exp_n == PREDICTED)
            foreach (step_pkts[i])
                expected_pkts.push_back(step_pkts[i]);
        else
            for (int i = 0; i < exp_n; i++)
                expected_pkts.push_back({exp_dests[i*NODE_W +: NODE_W], own_id, exp_best,
                                         1'b1 && (i == exp_n - 1)});
    endtask

    // stop sending and let every expected packet drain
    task automatic drain_packets();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_pkts.size() != 0);
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // packet checker and random output stalls
    always @(posedge clk)
    begin : packet_check
        vec_pkt_t want;
        vec_pkt_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[1:0], m_tdata[3:2], m_tdata[43:4], m_tlast};
            if (expected_pkts.size() == 0)
            begin
                $display("%0t: packet with none expected, expected nothing actual %h",
                         $time, got);
                fail_count++;
            end
            else
            begin
                want = expected_pkts.pop_front();
                check_field("to_node", want.to_node, got.to_node);
                check_field("from_node", want.from_node, got.from_node);
                for (int j = 0; j < NODES; j++)
                    check_field($sformatf("best_to_node%0d", j), want.best[j], got.best[j]);
                check_field("last_packet", want.last, got.last);
            end
        end
        m_tready <= !recv_gaps_on || ($urandom_range(0, 99) >= GAP_PCT);
    end

    // cycles since the last transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        route_item_t       it;
        cost_t             costs [NODES];
        logic [NODE_W-1:0] own;
        int                r;

        for (int d = 0; d < NODES; d++)
            for (int h = 0; h < NODES; h++)
                route_tbl[d][h] = INF;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset configuration: own node 0, links 0 1 3 7
        directed_rows.push_back(drow(KIND_UPDATE, 2'd1, cv(0, 0, 0, 0), 2'd0, 10'd0,
                                     0, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_LINK, 2'd0, cv(0, 0, 0, 0), 2'd2, 10'd5,
                                     PREDICTED, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_RESERVED, 2'd1, cv(1, 2, 3, 4), 2'd1, 10'd1,
                                     0, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_INIT, 2'd0, cv(0, 0, 0, 0), 2'd0, 10'd0,
                                     3, cv(0, 1, 3, 7), {2'd3, 2'd2, 2'd1}));
        directed_rows.push_back(drow(KIND_UPDATE, 2'd1, cv(1, 0, 1, 2), 2'd0, 10'd0,
                                     PREDICTED, ALL_INF, '0));
        // same vector again lowers nothing
        directed_rows.push_back(drow(KIND_UPDATE, 2'd1, cv(1, 0, 1, 2), 2'd0, 10'd0,
                                     0, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_UPDATE, 2'd2, cv(999, 999, 999, 999), 2'd0, 10'd0,
                                     0, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_UPDATE, 2'd3, cv(1023, 1023, 1023, 1023), 2'd0,
                                     10'd0, 0, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_UPDATE, 2'd3, cv(0, 0, 0, 0), 2'd0, 10'd0,
                                     PREDICTED, ALL_INF, '0));
        // vector from this node itself
        directed_rows.push_back(drow(KIND_UPDATE, 2'd0, cv(0, 0, 0, 0), 2'd0, 10'd0,
                                     PREDICTED, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_UPDATE, 2'd1, cv(998, 998, 998, 998), 2'd0, 10'd0,
                                     PREDICTED, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_LINK, 2'd0, cv(0, 0, 0, 0), 2'd3, 10'd1023,
                                     PREDICTED, ALL_INF, '0));
        // node 3 lost its link
        directed_rows.push_back(drow(KIND_UPDATE, 2'd3, cv(0, 0, 0, 0), 2'd0, 10'd0,
                                     0, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_LINK, 2'd0, cv(0, 0, 0, 0), 2'd0, 10'd500,
                                     PREDICTED, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_LINK, 2'd0, cv(0, 0, 0, 0), 2'd1, 10'd0,
                                     PREDICTED, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_RESERVED, 2'd3, cv(1023, 1023, 1023, 1023), 2'd3,
                                     10'd1023, 0, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_UPDATE, 2'd2, cv(0, 1023, 999, 512), 2'd0, 10'd0,
                                     PREDICTED, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_LINK, 2'd0, cv(0, 0, 0, 0), 2'd3, 10'd999,
                                     PREDICTED, ALL_INF, '0));
        directed_rows.push_back(drow(KIND_INIT, 2'd0, cv(0, 0, 0, 0), 2'd0, 10'd0,
                                     3, cv(0, 1, 3, 7), {2'd3, 2'd2, 2'd1}));
        directed_rows.push_back(drow(KIND_UPDATE, 2'd2, cv(2, 2, 0, 1), 2'd0, 10'd0,
                                     PREDICTED, ALL_INF, '0));

        foreach (directed_rows[i])
            apply_item(directed_rows[i].item, directed_rows[i].exp_n,
                       directed_rows[i].exp_best, directed_rows[i].exp_dests);

        // random phases, each on its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            drain_packets();
            repeat (SETTLE_CYCLES) @(posedge clk);
            send_gaps_on = (p != 2);
            recv_gaps_on = (p != 2);

            case (p)
                0:
                begin
                    own   = 2'd3;
                    costs = '{10'd1023, 10'd0, 10'd999, 10'd0};
                end
                1:
                begin
                    own   = 2'd1;
                    costs = '{INF, INF, INF, INF};
                end
                2:
                begin
                    own   = 2'd2;
                    costs = '{10'd0, 10'd0, 10'd0, 10'd0};
                end
                default:
                begin
                    own = NODE_W'($urandom_range(0, NODES - 1));
                    foreach (costs[d])
                        costs[d] = rand_cost();
                end
            endcase

            // upper data bits of the node id write are junk on purpose
            write_reg(CFG_OWN_NODE, cost_t'($urandom_range(0, 255) << NODE_W) | cost_t'(own));
            for (int d = 0; d < NODES; d++)
                write_reg(CFG_IDX_W'(CFG_INIT_COST0 + d), costs[d]);
            if (p == 3)
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          cost_t'($urandom_range(0, 1023)));
            cfg_valid <= 1'b0;

            it = '0;
            it.kind = KIND_INIT;
            apply_item(it, PREDICTED, ALL_INF, '0);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                it.kind = (r < 6) ? KIND_INIT : (r < 11) ? KIND_RESERVED :
                          (r < 33) ? KIND_LINK : KIND_UPDATE;
                it.sender = NODE_W'($urandom_range(0, NODES - 1));
                for (int d = 0; d < NODES; d++)
                    it.dists[d] = rand_cost();
                it.link      = NODE_W'($urandom_range(0, NODES - 1));
                it.link_cost = rand_cost();
                apply_item(it, PREDICTED, ALL_INF, '0);
                // hold the sender until the output side has caught up
                if (p == 3 && i == PHASE_ITEMS / 2)
                    drain_packets();
            end
        end

        drain_packets();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
